// ===== rtl/lpsp_pkg.sv =====
package lpsp_pkg;

  localparam int MAX_STEPS_DEF = 256;
  localparam int NUM_SETS_DEF  = 4;
  localparam int SET_DEPTH_DEF = 16;

  // field widths
  localparam int LEN_W  = 9;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 8;
  localparam int SET_W  = 2;
  localparam int WIDX_W = 4;
  localparam int CNT_W  = 32;
  localparam int DUTY_W = 16;
  localparam int SIZE_W = 5;

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_STEP  = 3'd1,
    OP_SIZE  = 3'd2,
    OP_WORD  = 3'd3,
    OP_START = 3'd4
  } op_t;

endpackage

// ===== rtl/lpsp_ram.sv =====
module lpsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first, output holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/led_pattern_sequence_player.sv =====
// pipeline: an accepted item passes the s1 and s2 registers to the output register
// intake: no item is taken while s1 holds one; the one read port of the pattern
//   store serves the set size read and then the duty word read of each tick
// reset: synchronous; clears the length register, counters, step, position, run flag
//   and the pipeline; step table and pattern store hold garbage until written,
//   no clearing pass
module led_pattern_sequence_player #(
  parameter int MAX_STEPS = lpsp_pkg::MAX_STEPS_DEF,
  parameter int NUM_SETS  = lpsp_pkg::NUM_SETS_DEF,
  parameter int SET_DEPTH = lpsp_pkg::SET_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpsp_pkg::LEN_W-1:0]    cfg_wr_data,    // sequence_length
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // step_index, set_index, word_index, step_duration, step_interval, duty_word, set_size
  input  logic [lpsp_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [lpsp_pkg::OP_W-1:0]     s_tuser,        // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpsp_pkg::M_DATA_W-1:0] m_tdata,        // duty, active
  output logic                          m_tuser,        // duty_update
  output logic                          m_tlast         // finished
);

  import lpsp_pkg::*;

  localparam int SAW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PD    = NUM_SETS * SET_DEPTH + NUM_SETS;
  localparam int PAW   = (PD > 1) ? $clog2(PD) : 1;
  localparam int WPW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int STA_W = SET_W + 2 * CNT_W;
  localparam int STB_W = SET_W + CNT_W;

  typedef struct packed {
    logic             hit;
    logic             set_ok;
    logic             fin;
    logic             active;
    logic [SET_W-1:0] set;
  } s1_t;

  typedef struct packed {
    logic upd;
    logic from_ram;
    logic fin;
    logic active;
  } s2_t;

  // input fields
  op_t               in_op;
  logic [IDX_W-1:0]  in_step_index;
  logic [SET_W-1:0]  in_set_index;
  logic [WIDX_W-1:0] in_word_index;
  logic [CNT_W-1:0]  in_duration;
  logic [CNT_W-1:0]  in_interval;
  logic [DUTY_W-1:0] in_duty_word;
  logic [SIZE_W-1:0] in_set_size;

  assign in_op         = op_t'(s_tuser);
  assign in_step_index = s_tdata[7:0];
  assign in_set_index  = s_tdata[9:8];
  assign in_word_index = s_tdata[13:10];
  assign in_duration   = s_tdata[45:14];
  assign in_interval   = s_tdata[77:46];
  assign in_duty_word  = s_tdata[93:78];
  assign in_set_size   = s_tdata[98:94];

  // state
  logic [LEN_W-1:0] seq_len;
  logic [CNT_W-1:0] interval_count, interval_count_next;
  logic [CNT_W-1:0] duration_count, duration_count_next;
  logic [SAW-1:0]   step_now, step_now_next;
  logic [WPW-1:0]   word_pos;
  logic             running, running_next;

  // pipeline
  logic s1_valid, s2_valid;
  s1_t  s1, s1_next;
  s2_t  s2;
  logic s1_move, s2_move, accept;

  // memories
  logic [STA_W-1:0] sta_rdata;
  logic [STB_W-1:0] stb_rdata;
  logic             st_we;
  logic [SAW-1:0]   st_waddr;
  logic [SAW:0]     step_inc;

  logic             pat_we, pat_re;
  logic [PAW-1:0]   pat_waddr, pat_raddr;
  logic [DUTY_W-1:0] pat_wdata, pat_rdata;

  // tick evaluation
  logic [CNT_W-1:0] cur_dur, cur_itv, nxt_itv, itv_sel;
  logic [SET_W-1:0] cur_set, nxt_set, set_sel;
  logic [CNT_W-1:0] dc_inc, ic_inc, eff_len;
  logic             adv, done, hit, set_sel_ok, is_tick;
  logic             exec_rd, wrap_rd;
  logic [PAW-1:0]   size_addr, word_addr;

  // position wrap
  logic [WPW:0]     pos_inc;
  logic [CNT_W-1:0] size_eff;
  logic [WPW-1:0]   new_pos;

  assign s2_move  = !m_tvalid || m_tready;
  assign s1_move  = !s2_valid || s2_move;
  assign s_tready = !s1_valid && (!s2_valid || s2_move);
  assign accept   = s_tvalid && s_tready;

  // step table, two copies so the current and the following step read together
  assign st_we    = accept && (in_op == OP_STEP) && (32'(in_step_index) < 32'(MAX_STEPS));
  assign st_waddr = SAW'(in_step_index);
  assign step_inc = {1'b0, step_now} + 1'b1;

  lpsp_ram #(.WIDTH(STA_W), .DEPTH(MAX_STEPS), .AW(SAW)) u_step_cur (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({in_set_index, in_interval, in_duration}),
    .re    (1'b1),
    .raddr (step_now),
    .rdata (sta_rdata)
  );

  lpsp_ram #(.WIDTH(STB_W), .DEPTH(MAX_STEPS), .AW(SAW)) u_step_nxt (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({in_set_index, in_interval}),
    .re    (1'b1),
    .raddr (SAW'(step_inc)),
    .rdata (stb_rdata)
  );

  assign cur_dur = sta_rdata[CNT_W-1:0];
  assign cur_itv = sta_rdata[2*CNT_W-1:CNT_W];
  assign cur_set = sta_rdata[STA_W-1:2*CNT_W];
  assign nxt_itv = stb_rdata[CNT_W-1:0];
  assign nxt_set = stb_rdata[STB_W-1:CNT_W];

  // tick decision
  assign eff_len = (32'(seq_len) > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : 32'(seq_len);
  assign is_tick = accept && (in_op == OP_TICK) && running;
  assign dc_inc  = duration_count + 1'b1;
  assign ic_inc  = interval_count + 1'b1;
  assign adv     = dc_inc >= cur_dur;
  assign done    = adv && (32'(step_inc) >= eff_len);
  // on a step change the interval test already uses the new step
  assign itv_sel = adv ? nxt_itv : cur_itv;
  assign set_sel = adv ? nxt_set : cur_set;
  assign hit     = !done && (ic_inc >= itv_sel);
  assign set_sel_ok = 32'(set_sel) < 32'(NUM_SETS);

  always_comb begin
    interval_count_next = interval_count;
    duration_count_next = duration_count;
    step_now_next       = step_now;
    running_next        = running;
    s1_next.hit         = 1'b0;
    s1_next.fin         = 1'b0;
    s1_next.set         = set_sel;
    s1_next.set_ok      = set_sel_ok;
    unique case (in_op)
      OP_TICK: begin
        if (running) begin
          duration_count_next = adv ? '0 : dc_inc;
          step_now_next       = adv ? SAW'(step_inc) : step_now;
          interval_count_next = hit ? '0 : ic_inc;
          running_next        = !done;
          s1_next.hit         = hit;
          s1_next.fin         = done;
        end
      end
      OP_START: begin
        if (eff_len != '0) begin
          interval_count_next = '0;
          duration_count_next = '0;
          step_now_next       = '0;
          running_next        = 1'b1;
        end
      end
      default: begin
      end
    endcase
    s1_next.active = running_next;
  end

  // pattern store: set words first, then one size entry per set
  assign size_addr = PAW'(NUM_SETS * SET_DEPTH) + PAW'(set_sel);
  assign exec_rd   = is_tick && hit && set_sel_ok;

  assign pos_inc  = {1'b0, word_pos} + 1'b1;
  assign size_eff = !s1.set_ok ? '0 :
                    (32'(pat_rdata[SIZE_W-1:0]) > 32'(SET_DEPTH)) ? 32'(SET_DEPTH) :
                    32'(pat_rdata[SIZE_W-1:0]);
  assign new_pos  = (32'(pos_inc) >= size_eff) ? '0 : WPW'(pos_inc);
  assign word_addr = PAW'(s1.set) * PAW'(SET_DEPTH) + PAW'(new_pos);
  assign wrap_rd  = s1_valid && s1_move && s1.hit && s1.set_ok;

  always_comb begin
    pat_we    = 1'b0;
    pat_waddr = size_addr;
    pat_wdata = DUTY_W'(in_set_size);
    if (accept && (in_op == OP_SIZE) && (32'(in_set_index) < 32'(NUM_SETS))) begin
      pat_we    = 1'b1;
      pat_waddr = PAW'(NUM_SETS * SET_DEPTH) + PAW'(in_set_index);
    end else if (accept && (in_op == OP_WORD) && (32'(in_set_index) < 32'(NUM_SETS)) &&
                 (32'(in_word_index) < 32'(SET_DEPTH))) begin
      pat_we    = 1'b1;
      pat_waddr = PAW'(in_set_index) * PAW'(SET_DEPTH) + PAW'(in_word_index);
      pat_wdata = in_duty_word;
    end
  end

  // size read and word read never fall in the same cycle
  assign pat_re    = exec_rd || wrap_rd;
  assign pat_raddr = wrap_rd ? word_addr : size_addr;

  lpsp_ram #(.WIDTH(DUTY_W), .DEPTH(PD), .AW(PAW)) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (pat_re),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len        <= '0;
      interval_count <= '0;
      duration_count <= '0;
      step_now       <= '0;
      word_pos       <= '0;
      running        <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seq_len <= cfg_wr_data;
      end
      if (accept) begin
        interval_count <= interval_count_next;
        duration_count <= duration_count_next;
        step_now       <= step_now_next;
        running        <= running_next;
      end
      if (accept && (in_op == OP_START) && (eff_len != '0)) begin
        word_pos <= '0;
      end else if (s1_valid && s1_move && s1.hit) begin
        word_pos <= new_pos;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_valid && s2_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_valid && s1_move) begin
      s2.upd      <= s1.hit || s1.fin;
      s2.from_ram <= s1.hit && s1.set_ok;
      s2.fin      <= s1.fin;
      s2.active   <= s1.active;
    end
    if (s2_valid && s2_move) begin
      m_tuser <= s2.upd;
      m_tlast <= s2.fin;
      m_tdata <= {{(M_DATA_W - DUTY_W - 1){1'b0}}, s2.active,
                  (s2.from_ram ? pat_rdata : {DUTY_W{1'b0}})};
    end
  end

endmodule

// ===== bench/led_pattern_sequence_player_test.sv =====
module led_pattern_sequence_player_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpsp_pkg::*;

  // ops outside the defined set, the block must ignore them
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  step_index;
    logic [SET_W-1:0]  set_index;
    logic [WIDX_W-1:0] word_index;
    logic [CNT_W-1:0]  duration;
    logic [CNT_W-1:0]  interval;
    logic [DUTY_W-1:0] word;
    logic [SIZE_W-1:0] size;
  } led_item_t;

  typedef struct packed {
    logic              update;
    logic [DUTY_W-1:0] duty;
    logic              active;
    logic              finished;
  } duty_result_t;

  class duty_scoreboard;
    bit [LEN_W-1:0]  seq_len;
    bit [CNT_W-1:0]  itv_cnt;
    bit [CNT_W-1:0]  dur_cnt;
    bit [LEN_W-1:0]  step_pos;
    bit [WIDX_W-1:0] word_pos;
    bit              running;
    bit [CNT_W-1:0]  step_dur [MAX_STEPS_DEF];
    bit [CNT_W-1:0]  step_itv [MAX_STEPS_DEF];
    bit [SET_W-1:0]  step_set [MAX_STEPS_DEF];
    bit [SIZE_W-1:0] set_size [NUM_SETS_DEF];
    bit [DUTY_W-1:0] set_word [NUM_SETS_DEF*SET_DEPTH_DEF];
    duty_result_t    expected_q[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     updates;
    int unsigned     finishes;

    function void set_length(bit [LEN_W-1:0] value);
      seq_len = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit is_running();
      return running;
    endfunction

    // a step number past the table reads entry 0
    function bit [IDX_W-1:0] cur_index();
      return (step_pos < MAX_STEPS_DEF) ? step_pos[IDX_W-1:0] : '0;
    endfunction

    function void note_item(led_item_t it);
      duty_result_t    r;
      int unsigned     eff_len;
      bit              done;
      bit [SET_W-1:0]  s;
      bit [SIZE_W-1:0] sz;
      bit [WIDX_W:0]   nxt;
      r = '0;
      done = 1'b0;
      eff_len = (seq_len > MAX_STEPS_DEF) ? MAX_STEPS_DEF : seq_len;
      case (it.op)
        OP_STEP: begin
          step_dur[it.step_index] = it.duration;
          step_itv[it.step_index] = it.interval;
          step_set[it.step_index] = it.set_index;
        end
        OP_SIZE: set_size[it.set_index] = it.size;
        OP_WORD: set_word[{it.set_index, it.word_index}] = it.word;
        OP_START: begin
          if (eff_len != 0) begin
            itv_cnt = '0;
            dur_cnt = '0;
            step_pos = '0;
            word_pos = '0;
            running = 1'b1;
          end
        end
        OP_TICK: begin
          if (running) begin
            itv_cnt++;
            dur_cnt++;
            if (dur_cnt >= step_dur[cur_index()]) begin
              dur_cnt = '0;
              step_pos++;
              if (step_pos >= eff_len) begin
                running = 1'b0;
                r.update = 1'b1;
                r.finished = 1'b1;
                done = 1'b1;
              end
            end
            // interval test sees the step that may just have been entered
            if (!done && itv_cnt >= step_itv[cur_index()]) begin
              s = step_set[cur_index()];
              sz = (set_size[s] > SET_DEPTH_DEF) ? SIZE_W'(SET_DEPTH_DEF) : set_size[s];
              itv_cnt = '0;
              nxt = {1'b0, word_pos} + 1'b1;
              if (nxt >= sz) nxt = '0;
              word_pos = nxt[WIDX_W-1:0];
              r.update = 1'b1;
              r.duty = set_word[{s, word_pos}];
            end
          end
        end
        default: ;
      endcase
      r.active = running;
      expected_q.push_back(r);
    endfunction

    function void check_result(duty_result_t got);
      duty_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: upd %b duty %h active %b fin %b",
                   got.update, got.duty, got.active, got.finished);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.update) updates++;
      if (exp.finished) finishes++;
      if (got.update !== exp.update || got.duty !== exp.duty ||
          got.active !== exp.active || got.finished !== exp.finished) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d mismatch: expected upd %b duty %h active %b fin %b,",
                    " got upd %b duty %h active %b fin %b"},
                   checked, exp.update, exp.duty, exp.active, exp.finished,
                   got.update, got.duty, got.active, got.finished);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [LEN_W-1:0]    cfg_wr_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [OP_W-1:0]     s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  duty_scoreboard sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_req;
  int unsigned    items_sent;

  led_pattern_sequence_player dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random backpressure, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    duty_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.update = m_tuser;
        got.duty = m_tdata[DUTY_W-1:0];
        got.active = m_tdata[DUTY_W];
        got.finished = m_tlast;
        sb.check_result(got);
      end
    end
  end

  function automatic led_item_t noise_item(logic [OP_W-1:0] op);
    led_item_t it;
    it.op = op;
    it.step_index = IDX_W'($urandom);
    it.set_index = SET_W'($urandom);
    it.word_index = WIDX_W'($urandom);
    it.duration = $urandom;
    it.interval = $urandom;
    it.word = DUTY_W'($urandom);
    it.size = SIZE_W'($urandom);
    return it;
  endfunction

  task automatic send_item(led_item_t it);
    bit go;
    go = 1'b0;
    while (!go) begin
      @(negedge clk);
      go = ($urandom_range(99) >= send_idle_pct);
      if (!go) s_tvalid <= 1'b0;
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= S_DATA_W'({it.size, it.word, it.interval, it.duration,
                          it.word_index, it.set_index, it.step_index});
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_op(logic [OP_W-1:0] op);
    send_item(noise_item(op));
  endtask

  task automatic send_step(int idx, logic [CNT_W-1:0] dur, logic [CNT_W-1:0] itv, int set);
    led_item_t it;
    it = noise_item(OP_STEP);
    it.step_index = IDX_W'(idx);
    it.duration = dur;
    it.interval = itv;
    it.set_index = SET_W'(set);
    send_item(it);
  endtask

  task automatic send_size(int set, int size);
    led_item_t it;
    it = noise_item(OP_SIZE);
    it.set_index = SET_W'(set);
    it.size = SIZE_W'(size);
    send_item(it);
  endtask

  task automatic send_word(int set, int idx, logic [DUTY_W-1:0] word);
    led_item_t it;
    it = noise_item(OP_WORD);
    it.set_index = SET_W'(set);
    it.word_index = WIDX_W'(idx);
    it.word = word;
    send_item(it);
  endtask

  // sender pauses until every result is back and the pipeline is empty
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_length(int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LEN_W'(value);
    sb.set_length(LEN_W'(value));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic pick_length();
    int r;
    r = $urandom_range(9);
    if (r == 0) write_length(0);
    else if (r == 1) write_length(MAX_STEPS_DEF);
    else if (r == 2) write_length($urandom_range(MAX_STEPS_DEF));
    else write_length($urandom_range(6, 1));
  endtask

  // mostly ticks, with table rewrites, restarts and spare ops mixed in
  task automatic run_phase(int count);
    int pick;
    int idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_op(OP_START);
      end else if (pick < 7) begin
        send_op(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)));
      end else if (pick < 11) begin
        idx = ($urandom_range(3) == 0) ? $urandom_range(MAX_STEPS_DEF - 1) : $urandom_range(7);
        send_step(idx,
                  ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6),
                  ($urandom_range(7) == 0) ? $urandom : $urandom_range(5),
                  $urandom_range(NUM_SETS_DEF - 1));
      end else if (pick < 13) begin
        send_size($urandom_range(NUM_SETS_DEF - 1), $urandom_range(SET_DEPTH_DEF, 1));
      end else if (pick < 17) begin
        send_word($urandom_range(NUM_SETS_DEF - 1), $urandom_range(SET_DEPTH_DEF - 1),
                  DUTY_W'($urandom));
      end else begin
        send_op(OP_TICK);
      end
    end
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    m_tready = 1'b0;
    hold_req = 0;
    items_sent = 0;
    send_idle_pct = 37;
    recv_idle_pct = 68;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // fill every table entry before anything can be played
    for (int s = 0; s < NUM_SETS_DEF; s++) send_size(s, $urandom_range(SET_DEPTH_DEF, 1));
    for (int s = 0; s < NUM_SETS_DEF; s++)
      for (int w = 0; w < SET_DEPTH_DEF; w++) send_word(s, w, DUTY_W'($urandom));
    for (int i = 0; i < MAX_STEPS_DEF; i++)
      send_step(i, $urandom_range(5), $urandom_range(4), $urandom_range(NUM_SETS_DEF - 1));

    // zero length start is ignored, idle ticks and spare ops do nothing
    wait_drained();
    write_length(0);
    send_op(OP_START);
    send_op(OP_TICK);
    send_op(OP_SPARE_LO);
    send_op(OP_SPARE_HI);
    send_step(0, '1, '1, NUM_SETS_DEF - 1);
    send_step(MAX_STEPS_DEF - 1, '0, '0, 0);
    send_size(0, 0);
    send_size(NUM_SETS_DEF - 1, 31);
    send_size(1, SET_DEPTH_DEF);
    send_size(2, 1);
    send_word(NUM_SETS_DEF - 1, SET_DEPTH_DEF - 1, '1);
    send_word(0, 0, '0);
    wait_drained();
    write_length(1);
    send_op(OP_START);
    send_op(OP_TICK);
    send_op(OP_TICK);
    // restart while running, then shrink the step so it ends
    send_op(OP_START);
    send_step(0, 3, 0, NUM_SETS_DEF - 1);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_op(OP_TICK);
    // step change and interval expiry on the same tick, empty set, zero duration
    send_step(1, 0, 2, 0);
    wait_drained();
    write_length(2);
    send_op(OP_START);
    repeat (4) send_op(OP_TICK);

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 37 : (regime == 1) ? 68 : 0;
      recv_idle_pct = (regime == 0) ? 68 : (regime == 1) ? 37 : 0;
      for (int ph = 0; ph < 9; ph++) begin
        wait_drained();
        pick_length();
        if (regime == 2 && ph == 3) hold_req = 80;
        if ($urandom_range(3) != 0) send_op(OP_START);
        run_phase(28);
      end
    end

    // one full pass over the whole table
    wait_drained();
    write_length(MAX_STEPS_DEF);
    send_op(OP_START);
    guard = 0;
    while (sb.is_running() && guard < 3000) begin
      send_op(OP_TICK);
      guard++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d items over table loads, restarts and length changes; %0d results checked",
             items_sent, sb.checked);
    $display("%0d duty updates and %0d sequence ends seen, %0d mismatches",
             sb.updates, sb.finishes, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpsp_pkg.sv
rtl/lpsp_ram.sv
rtl/led_pattern_sequence_player.sv
bench/led_pattern_sequence_player_test.sv
